[src/etab_pkg.sv]
// Shared types and constants for the embargo table.
`default_nettype none
package etab_pkg;

    localparam int POOL_DEPTH = 32;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int VCNT_W     = 6;
    localparam int MAX_RES    = 32;
    localparam int KEY_W      = 256;
    localparam int TIME_W     = 40;
    localparam int DL_W       = 41;
    localparam int EMB_W      = 16;
    localparam int LIM_W      = 6;
    localparam int TOT_W      = 32;

    localparam logic [1:0] KIND_ADD      = 2'd0;
    localparam logic [1:0] KIND_REMOVE   = 2'd1;
    localparam logic [1:0] KIND_CONTAINS = 2'd2;
    localparam logic [1:0] KIND_SWEEP    = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [DL_W-1:0]   deadline;
    } entry_t;

endpackage
`default_nettype wire

[src/etab_cell.sv]
// One slot of the rotating entry ring.
`default_nettype none
module etab_cell (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            shift_en,
    input  etab_pkg::entry_t     d,
    output etab_pkg::entry_t     q
);

    logic                       valid_reg;
    logic [etab_pkg::KEY_W-1:0] key_reg;
    logic [etab_pkg::DL_W-1:0]  deadline_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= d.valid;
        end
    end

    // Key and deadline carry no reset; the valid mark guards them.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            key_reg      <= d.key;
            deadline_reg <= d.deadline;
        end
    end

    assign q.valid    = valid_reg;
    assign q.key      = key_reg;
    assign q.deadline = deadline_reg;

endmodule
`default_nettype wire

[src/embargo_table_with_dedup_and_expiry_core.sv]
// Top level of the embargo table: entry ring, scan controller and result register.
//
// Requests enter on the s_ channel (tuser holds the kind, tdata the key, the time
// and the sweep limit) and results leave on the m_ channel; tlast marks the final
// result of a request. The embargo setting is written on the cfg_ channel, which
// is always ready and is meant to be written while the block is idle.
// The entries sit in a ring of POOL_DEPTH cells that rotates by one slot a cycle during
// a scan or write-back, so the controller sees one entry at a time at the head of the ring.
// Every request takes a scan rotation of the ring and a decision step.
// Contains, add of a present key, remove of an absent key and a sweep with nothing
// to expire then answer from the response state. Add of a new key, remove of a
// present key and a sweep that finds expired keys take a second rotation that
// writes the change back; add and remove answer after it, from the response state.
// One request is in the block at a time. A sweep hands out each expired key, up to
// its limit, during its second rotation; if the receiver stalls, the ring holds
// still until the result register is free.
// Reset clears every valid mark, the entry count and the expiry total, and sets
// the embargo to 30 seconds; no clearing pass is needed.
`default_nettype none
module embargo_table_with_dedup_and_expiry_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // key_word0, key_word1, key_word2, key_word3, now_secs, max_out, two zero bits
    input  wire logic [303:0] s_tdata,
    // kind
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_word0, out_word1, out_word2, out_word3, pool_count, expired_total, two zero bits
    output logic [295:0]      m_tdata,
    // flag, evicted
    output logic [1:0]        m_tuser,
    output logic              m_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [15:0]  cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_MOD    = 3'd3;
    localparam logic [2:0] ST_RESP   = 3'd4;
    localparam logic [etab_pkg::IDX_W-1:0] LAST_IDX =
        etab_pkg::IDX_W'(etab_pkg::POOL_DEPTH - 1);

    logic [2:0] state_reg, state_next;
    logic [etab_pkg::IDX_W-1:0] step_reg;

    logic [1:0]                   kind_reg;
    logic [etab_pkg::KEY_W-1:0]   key_reg;
    logic [etab_pkg::TIME_W-1:0]  now_reg;
    logic [etab_pkg::LIM_W-1:0]   lim_reg;
    logic [etab_pkg::EMB_W-1:0]   emb_reg;

    logic                         found_reg, have_free_reg, have_old_reg;
    logic [etab_pkg::IDX_W-1:0]   found_idx_reg, free_idx_reg, old_idx_reg, target_reg;
    logic [etab_pkg::DL_W-1:0]    best_reg;
    logic [etab_pkg::LIM_W-1:0]   elig_reg, emit_reg;
    logic                         flag_reg, ev_reg, do_write_reg;

    logic [etab_pkg::VCNT_W-1:0]  vcount_reg;
    logic [etab_pkg::TOT_W-1:0]   expired_reg;

    logic                         out_valid_reg, out_flag_reg, out_ev_reg, out_last_reg;
    logic [etab_pkg::KEY_W-1:0]   out_key_reg;
    logic [etab_pkg::VCNT_W-1:0]  out_cnt_reg;
    logic [etab_pkg::TOT_W-1:0]   out_tot_reg;

    etab_pkg::entry_t cell_q [etab_pkg::POOL_DEPTH];
    etab_pkg::entry_t head, wb;
    logic shift_en;

    logic head_match, head_expired, out_free, sweep_emit;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);

    for (genvar i = 0; i < etab_pkg::POOL_DEPTH; i++) begin : g_cell
        etab_pkg::entry_t d_in;
        if (i == etab_pkg::POOL_DEPTH - 1) begin : g_tail
            assign d_in = wb;
        end else begin : g_mid
            assign d_in = cell_q[i+1];
        end
        etab_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .d        (d_in),
            .q        (cell_q[i])
        );
    end

    assign head         = cell_q[0];
    assign head_match   = head.valid && (head.key == key_reg);
    assign head_expired = head.valid && ({1'b0, now_reg} >= head.deadline);
    assign out_free     = !out_valid_reg || m_tready;
    assign sweep_emit   = (state_reg == ST_MOD) && (kind_reg == etab_pkg::KIND_SWEEP)
                          && head_expired && (emit_reg < elig_reg);

    assign shift_en = (state_reg == ST_SCAN) ||
                      ((state_reg == ST_MOD) && !(sweep_emit && !out_free));

    // Write-back of the head entry as it wraps round to the tail.
    always_comb begin
        wb = head;
        if (state_reg == ST_MOD) begin
            if (kind_reg == etab_pkg::KIND_SWEEP) begin
                if (sweep_emit) begin
                    wb.valid = 1'b0;
                end
            end else if (do_write_reg && step_reg == target_reg) begin
                if (kind_reg == etab_pkg::KIND_ADD) begin
                    wb.valid    = 1'b1;
                    wb.key      = key_reg;
                    wb.deadline = {1'b0, now_reg} + etab_pkg::DL_W'(emb_reg);
                end else begin
                    wb.valid = 1'b0;
                end
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_SCAN;
            ST_SCAN:   if (step_reg == LAST_IDX) state_next = ST_DECIDE;
            ST_DECIDE: begin
                priority if (kind_reg == etab_pkg::KIND_SWEEP) begin
                    state_next = (elig_reg == '0) ? ST_RESP : ST_MOD;
                end else if (kind_reg == etab_pkg::KIND_ADD) begin
                    state_next = found_reg ? ST_RESP : ST_MOD;
                end else if (kind_reg == etab_pkg::KIND_REMOVE) begin
                    state_next = found_reg ? ST_MOD : ST_RESP;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_MOD: begin
                if (shift_en && step_reg == LAST_IDX) begin
                    state_next = (kind_reg == etab_pkg::KIND_SWEEP) ? ST_IDLE : ST_RESP;
                end
            end
            ST_RESP:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            emb_reg       <= etab_pkg::EMB_W'(30);
            vcount_reg    <= '0;
            expired_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                emb_reg <= cfg_data;
            end
            if (state_reg == ST_IDLE || state_reg == ST_DECIDE) begin
                step_reg <= '0;
            end else if (shift_en) begin
                step_reg <= (step_reg == LAST_IDX) ? '0 : step_reg + 1'b1;
            end
            if (state_reg == ST_DECIDE) begin
                unique case (kind_reg)
                    etab_pkg::KIND_ADD: begin
                        if (!found_reg && have_free_reg) begin
                            vcount_reg <= vcount_reg + 1'b1;
                        end
                    end
                    etab_pkg::KIND_REMOVE: begin
                        if (found_reg) begin
                            vcount_reg <= vcount_reg - 1'b1;
                        end
                    end
                    etab_pkg::KIND_CONTAINS: ;
                    etab_pkg::KIND_SWEEP: begin
                        vcount_reg  <= vcount_reg - etab_pkg::VCNT_W'(elig_reg);
                        expired_reg <= expired_reg + etab_pkg::TOT_W'(elig_reg);
                    end
                    default: ;
                endcase
            end
            if (sweep_emit && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (state_reg == ST_RESP && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture, scan bookkeeping and result payload.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            kind_reg      <= s_tuser;
            key_reg       <= s_tdata[255:0];
            now_reg       <= s_tdata[295:256];
            lim_reg       <= (s_tdata[301:296] > etab_pkg::LIM_W'(etab_pkg::MAX_RES)) ?
                             etab_pkg::LIM_W'(etab_pkg::MAX_RES) : s_tdata[301:296];
            found_reg     <= 1'b0;
            have_free_reg <= 1'b0;
            have_old_reg  <= 1'b0;
            elig_reg      <= '0;
            emit_reg      <= '0;
        end
        if (state_reg == ST_SCAN) begin
            if (head_match && !found_reg) begin
                found_reg     <= 1'b1;
                found_idx_reg <= step_reg;
            end
            if (!head.valid && !have_free_reg) begin
                have_free_reg <= 1'b1;
                free_idx_reg  <= step_reg;
            end
            if (head.valid && (!have_old_reg || head.deadline < best_reg)) begin
                have_old_reg <= 1'b1;
                best_reg     <= head.deadline;
                old_idx_reg  <= step_reg;
            end
            if (head_expired && elig_reg < lim_reg) begin
                elig_reg <= elig_reg + 1'b1;
            end
        end
        if (state_reg == ST_DECIDE) begin
            ev_reg       <= 1'b0;
            do_write_reg <= 1'b0;
            unique case (kind_reg)
                etab_pkg::KIND_ADD: begin
                    flag_reg     <= !found_reg;
                    ev_reg       <= !found_reg && !have_free_reg;
                    do_write_reg <= !found_reg;
                    target_reg   <= have_free_reg ? free_idx_reg : old_idx_reg;
                end
                etab_pkg::KIND_REMOVE: begin
                    flag_reg     <= found_reg;
                    do_write_reg <= found_reg;
                    target_reg   <= found_idx_reg;
                end
                etab_pkg::KIND_CONTAINS: begin
                    flag_reg <= found_reg;
                end
                etab_pkg::KIND_SWEEP: begin
                    flag_reg <= 1'b0;
                end
                default: ;
            endcase
        end
        // The count and total are captured with the result so they hold while it waits.
        if (sweep_emit && out_free) begin
            emit_reg     <= emit_reg + 1'b1;
            out_flag_reg <= 1'b1;
            out_ev_reg   <= 1'b0;
            out_key_reg  <= head.key;
            out_last_reg <= (emit_reg + 1'b1 == elig_reg);
            out_cnt_reg  <= vcount_reg;
            out_tot_reg  <= expired_reg;
        end else if (state_reg == ST_RESP && out_free) begin
            out_flag_reg <= flag_reg;
            out_ev_reg   <= ev_reg;
            out_key_reg  <= '0;
            out_last_reg <= 1'b1;
            out_cnt_reg  <= vcount_reg;
            out_tot_reg  <= expired_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_ev_reg, out_flag_reg};
    assign m_tdata  = {2'b00, out_tot_reg, out_cnt_reg, out_key_reg};

endmodule
`default_nettype wire

[tb/etab_scoreboard.sv]
// Checker for the embargo table: watches the channels, predicts every result and compares.
module etab_scoreboard
    import etab_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [303:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [295:0] m_tdata,
    input  logic [1:0]   m_tuser,
    input  logic         m_tlast,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [15:0]  cfg_data,
    output int           fail_count,
    output int           pending
);

    typedef struct packed {
        logic              flag;
        logic              evicted;
        logic [KEY_W-1:0]  key;
        logic              last;
        logic [VCNT_W-1:0] pool_count;
        logic [TOT_W-1:0]  total;
    } etab_result_t;

    etab_result_t      result_q[$];
    logic              slot_used[POOL_DEPTH];
    logic [KEY_W-1:0]  slot_key[POOL_DEPTH];
    logic [DL_W-1:0]   slot_deadline[POOL_DEPTH];
    int                used_count;
    logic [TOT_W-1:0]  released_total;
    logic [EMB_W-1:0]  embargo;

    assign pending = result_q.size();

    function automatic int find_slot(logic [KEY_W-1:0] k);
        for (int i = 0; i < POOL_DEPTH; i++)
            if (slot_used[i] && slot_key[i] == k) return i;
        return -1;
    endfunction

    // Works out the results of one request and updates the table copy.
    task automatic apply_request(logic [1:0] kind, logic [KEY_W-1:0] k,
                                 logic [TIME_W-1:0] now, logic [LIM_W-1:0] lim);
        etab_result_t batch[$];
        etab_result_t r;
        int hit;
        int slot;
        int oldest;
        int cap;
        r = '0;
        r.last = 1'b1;
        case (kind)
            KIND_ADD: begin
                if (find_slot(k) < 0) begin
                    slot = -1;
                    oldest = 0;
                    for (int i = 0; i < POOL_DEPTH; i++) begin
                        if (!slot_used[i]) begin
                            slot = i;
                            break;
                        end
                        if (slot_deadline[i] < slot_deadline[oldest]) oldest = i;
                    end
                    if (slot < 0) begin
                        slot = oldest;
                        r.evicted = 1'b1;
                    end else begin
                        used_count++;
                    end
                    slot_key[slot] = k;
                    slot_deadline[slot] = {1'b0, now} + DL_W'(embargo);
                    slot_used[slot] = 1'b1;
                    r.flag = 1'b1;
                end
                batch.push_back(r);
            end
            KIND_REMOVE, KIND_CONTAINS: begin
                hit = find_slot(k);
                if (hit >= 0 && kind == KIND_REMOVE) begin
                    slot_used[hit] = 1'b0;
                    used_count--;
                end
                r.flag = (hit >= 0);
                batch.push_back(r);
            end
            default: begin
                cap = (lim > MAX_RES) ? MAX_RES : int'(lim);
                for (int i = 0; i < POOL_DEPTH && batch.size() < cap; i++) begin
                    if (slot_used[i] && {1'b0, now} >= slot_deadline[i]) begin
                        r = '0;
                        r.flag = 1'b1;
                        r.key = slot_key[i];
                        batch.push_back(r);
                        slot_used[i] = 1'b0;
                        used_count--;
                        released_total++;
                    end
                end
                if (batch.size() == 0) begin
                    r = '0;
                    batch.push_back(r);
                end
                batch[batch.size()-1].last = 1'b1;
            end
        endcase
        // Count and total are reported as they stand after the whole request.
        foreach (batch[i]) begin
            batch[i].pool_count = VCNT_W'(used_count);
            batch[i].total = released_total;
            result_q.push_back(batch[i]);
        end
    endtask

    always @(posedge aclk) begin
        etab_result_t got;
        etab_result_t want;
        if (!aresetn) begin
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            used_count = 0;
            released_total = '0;
            embargo = 16'd30;
            result_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) embargo = cfg_data;
            if (s_tvalid && s_tready)
                apply_request(s_tuser, s_tdata[255:0], s_tdata[295:256], s_tdata[301:296]);
            if (m_tvalid && m_tready) begin
                got.flag = m_tuser[0];
                got.evicted = m_tuser[1];
                got.key = m_tdata[255:0];
                got.last = m_tlast;
                got.pool_count = m_tdata[261:256];
                got.total = m_tdata[293:262];
                if (result_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: flag=%b ev=%b last=%b cnt=%0d tot=%0d",
                                 got.flag, got.evicted, got.last, got.pool_count, got.total);
                end else begin
                    want = result_q.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: expected flag=%b ev=%b last=%b cnt=%0d tot=%0d",
                                     want.flag, want.evicted, want.last, want.pool_count,
                                     want.total);
                            $display("          actual   flag=%b ev=%b last=%b cnt=%0d tot=%0d",
                                     got.flag, got.evicted, got.last, got.pool_count,
                                     got.total);
                            $display("          key expected %h", want.key);
                            $display("          key actual   %h", got.key);
                        end
                    end
                end
            end
        end
    end

endmodule

[tb/embargo_table_with_dedup_and_expiry_core_tb.sv]
// Testbench top for the embargo table: clock, reset, request and setting stimulus, verdict.
module embargo_table_with_dedup_and_expiry_core_tb;
    import etab_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [303:0] s_tdata = '0;
    logic [1:0]   s_tuser = KIND_ADD;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [295:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [15:0]  cfg_data = '0;
    int           fail_count;
    int           pending;
    int           cycles = 0;
    logic         quiet = 1'b0;

    logic [KEY_W-1:0]  key_pool[48];
    logic [TIME_W-1:0] clock_now;

    always #10 aclk = ~aclk;

    embargo_table_with_dedup_and_expiry_core i_dut (.*);

    etab_scoreboard i_scoreboard (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 1_000_000) begin
            $display("** embargo_table_with_dedup_and_expiry_core: FAILED **");
            $finish;
        end
    end

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        logic [KEY_W-1:0] k;
        for (int i = 0; i < 8; i++) k[32*i +: 32] = $urandom;
        return k;
    endfunction

    // Result side: stalls a random number of cycles before each result.
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_request(logic [1:0] kind, logic [KEY_W-1:0] k,
                                logic [TIME_W-1:0] now, logic [LIM_W-1:0] lim);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, lim, now, k};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Settings change only once every result is back and the scan has run out.
    task automatic set_embargo(logic [15:0] secs);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= secs;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int count);
        logic [1:0] kind;
        logic [KEY_W-1:0] k;
        logic [LIM_W-1:0] lim;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            kind = pick < 45 ? KIND_ADD : pick < 60 ? KIND_REMOVE :
                   pick < 75 ? KIND_CONTAINS : KIND_SWEEP;
            k = ($urandom_range(0, 9) == 0) ? random_key() : key_pool[$urandom_range(0, 47)];
            lim = ($urandom_range(0, 3) == 0) ? LIM_W'($urandom_range(0, 63))
                                              : LIM_W'($urandom_range(1, 6));
            if ($urandom_range(0, 19) == 0)
                clock_now = clock_now + TIME_W'($urandom_range(0, 100000));
            else
                clock_now = clock_now + TIME_W'($urandom_range(0, 12));
            send_request(kind, k, clock_now, lim);
        end
    endtask

    initial begin
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 48; i++) key_pool[i] = random_key();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extreme keys, duplicates, lookups, empty and capped sweeps.
        clock_now = 40'd1000;
        send_request(KIND_SWEEP, '0, clock_now, 6'd5);
        send_request(KIND_ADD, key_pool[0], clock_now, '0);
        send_request(KIND_ADD, key_pool[1], clock_now, '1);
        send_request(KIND_ADD, key_pool[1], clock_now, '0);
        send_request(KIND_CONTAINS, key_pool[1], clock_now, '0);
        send_request(KIND_CONTAINS, key_pool[2], clock_now, '0);
        send_request(KIND_REMOVE, key_pool[0], clock_now, '0);
        send_request(KIND_REMOVE, key_pool[0], clock_now, '0);
        send_request(KIND_ADD, key_pool[3], clock_now + 40'd10, '0);
        send_request(KIND_ADD, key_pool[4], clock_now + 40'd5, '0);
        send_request(KIND_SWEEP, '0, clock_now + 40'd29, 6'd32);
        send_request(KIND_SWEEP, '0, clock_now + 40'd40, 6'd0);
        send_request(KIND_SWEEP, '0, clock_now + 40'd40, 6'd1);
        send_request(KIND_SWEEP, '0, clock_now + 40'd100, 6'd63);
        send_request(KIND_ADD, key_pool[5], 40'hFF_FFFF_FFFF, '0);
        send_request(KIND_SWEEP, '1, 40'hFF_FFFF_FFFF, 6'd40);

        clock_now = TIME_W'($urandom_range(0, 1000));
        random_phase(120);
        set_embargo(16'd0);
        quiet = 1'b1;
        clock_now = TIME_W'({$urandom, $urandom} >> 24);
        random_phase(60);
        quiet = 1'b0;
        random_phase(50);
        set_embargo(16'hFFFF);
        clock_now = 40'hFF_FFF0_0000;
        random_phase(110);
        set_embargo(16'd7);
        clock_now = TIME_W'({$urandom, $urandom} >> 24);
        random_phase(110);

        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("** embargo_table_with_dedup_and_expiry_core: PASSED **");
        else
            $display("** embargo_table_with_dedup_and_expiry_core: FAILED **");
        $finish;
    end

endmodule

[embargo_table_with_dedup_and_expiry_core.f]
src/etab_pkg.sv
src/etab_cell.sv
src/embargo_table_with_dedup_and_expiry_core.sv
tb/etab_scoreboard.sv
tb/embargo_table_with_dedup_and_expiry_core_tb.sv
